// File: hdl/clock_date_setting_editor_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the clock date setting editor
// Concurrent checks sampled on clk, switched off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef CLOCK_DATE_SETTING_EDITOR_UNIT_ASSERT_SVH
`define CLOCK_DATE_SETTING_EDITOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define CDSE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cdse assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CDSE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cdse assertion failed");

`else

`define CDSE_ASSERT_SAME(lbl, ante, cons)
`define CDSE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/cdse_pkg.sv
// ---------------------------------------------------------------------------
// Clock date setting editor package
// Codes, reset values, the editor state type and the calendar helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package cdse_pkg;

	// Joystick operations carried in the input tuser.
	localparam logic [2:0] OP_LEFT   = 3'd0;
	localparam logic [2:0] OP_RIGHT  = 3'd1;
	localparam logic [2:0] OP_UP     = 3'd2;
	localparam logic [2:0] OP_DOWN   = 3'd3;
	localparam logic [2:0] OP_CENTER = 3'd4;
	localparam logic [2:0] OP_LOAD   = 3'd5;

	// Display modes.
	localparam logic [2:0] MODE_STANDARD = 3'd0;
	localparam logic [2:0] MODE_TIME     = 3'd1;
	localparam logic [2:0] MODE_ALARM    = 3'd2;
	localparam logic [2:0] MODE_MUSIC    = 3'd3;
	localparam logic [2:0] MODE_RINGING  = 3'd4;
	localparam logic [2:0] MODE_DATE     = 3'd5;

	// Cursor positions; the last code selects no field.
	localparam logic [1:0] CUR_FIRST  = 2'd0;
	localparam logic [1:0] CUR_SECOND = 2'd1;
	localparam logic [1:0] CUR_THIRD  = 2'd2;
	localparam logic [1:0] CUR_NONE   = 2'd3;

	// Field limits and reset values.
	localparam logic [5:0]  HOUR_TOP     = 6'd23;
	localparam logic [5:0]  MINSEC_TOP   = 6'd59;
	localparam logic [13:0] YEAR_MAX     = 14'd9999;
	localparam logic [13:0] CAL_YEAR_RST = 14'd2019;
	localparam logic [4:0]  CAL_DAY_RST  = 5'd1;
	localparam logic [3:0]  CAL_MONTH_RST = 4'd1;

	// Reciprocal of 100 scaled by 2^19, exact enough for any 14-bit year.
	localparam int unsigned RECIP100       = 5243;
	localparam int unsigned RECIP100_SHIFT = 19;

	// Stream widths.
	localparam int unsigned IN_TDATA_W  = 32;
	localparam int unsigned IN_TUSER_W  = 3;
	localparam int unsigned OUT_TDATA_W = 64;

	// Complete editor state.
	typedef struct packed {
		logic [2:0]  menu;
		logic [1:0]  tcur;
		logic [1:0]  acur;
		logic [1:0]  dcur;
		logic [4:0]  set_hour;
		logic [5:0]  set_minute;
		logic [5:0]  set_second;
		logic [4:0]  wake_hour;
		logic [5:0]  wake_minute;
		logic [5:0]  wake_second;
		logic [4:0]  cal_day;
		logic [3:0]  cal_month;
		logic [13:0] cal_year;
	} cdse_state_t;

	// Gregorian leap year. Divisibility by 100 is read from the fraction of
	// the reciprocal product: an exact multiple leaves a fraction of 12 per
	// hundred, which stays far below the reciprocal itself.
	function automatic logic is_leap(input logic [13:0] y);
		logic [26:0] prod;
		logic [7:0]  q;
		logic        div100;
		logic        div400;
		prod   = 27'(y) * 27'(RECIP100);
		q      = prod[26:RECIP100_SHIFT];
		div100 = (prod[RECIP100_SHIFT-1:0] < 19'(RECIP100));
		div400 = div100 && (q[1:0] == 2'd0);
		return (y[1:0] == 2'd0) && (!div100 || div400);
	endfunction

	// Days in a month; zero for a month code outside one to twelve.
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic [13:0] y);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = is_leap(y) ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// Menu selection stepped left; the entry four is skipped.
	function automatic logic [2:0] menu_left(input logic [2:0] s);
		logic [2:0] n;
		unique case (s)
			3'd0: n = 3'd5;
			3'd1: n = 3'd0;
			3'd2: n = 3'd1;
			3'd3: n = 3'd2;
			3'd4: n = 3'd3;
			3'd5: n = 3'd3;
			3'd6: n = 3'd0;
			default: n = 3'd1;
		endcase
		return n;
	endfunction

	// Menu selection stepped right.
	function automatic logic [2:0] menu_right(input logic [2:0] s);
		logic [2:0] n;
		unique case (s)
			3'd0: n = 3'd1;
			3'd1: n = 3'd2;
			3'd2: n = 3'd3;
			3'd3: n = 3'd5;
			3'd4: n = 3'd5;
			3'd5: n = 3'd0;
			3'd6: n = 3'd1;
			default: n = 3'd2;
		endcase
		return n;
	endfunction

	// Field cursor stepped left.
	function automatic logic [1:0] cursor_left(input logic [1:0] c);
		logic [1:0] n;
		unique case (c)
			CUR_FIRST:  n = CUR_THIRD;
			CUR_SECOND: n = CUR_FIRST;
			CUR_THIRD:  n = CUR_SECOND;
			default:    n = CUR_FIRST;
		endcase
		return n;
	endfunction

	// Field cursor stepped right.
	function automatic logic [1:0] cursor_right(input logic [1:0] c);
		logic [1:0] n;
		unique case (c)
			CUR_FIRST:  n = CUR_SECOND;
			CUR_SECOND: n = CUR_THIRD;
			CUR_THIRD:  n = CUR_FIRST;
			default:    n = CUR_SECOND;
		endcase
		return n;
	endfunction

	// Hour, minute or second stepped with wraparound at top.
	function automatic logic [5:0] hms_step(input logic [5:0] v, input logic [5:0] top,
			input logic up);
		logic [5:0] n;
		if (up) begin
			n = (v >= top) ? 6'd0 : v + 6'd1;
		end else begin
			n = (v == 6'd0 || v > top) ? top : v - 6'd1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: hdl/clock_date_setting_editor_unit.sv
// ---------------------------------------------------------------------------
// Clock date setting editor
// Joystick driven editor for the menu selection, time, alarm and date.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Beat contents
// s_axis    in         tuser: operation; tdata: mode, load_day, load_month, load_year
// m_axis    out        tdata: menu selection, time, alarm, date, alarm_off pulse
//
// One beat is taken every cycle unless m_axis_tready holds the result back;
// each input beat gives exactly one result beat. A beat waits in the input
// register, then the update logic and the month length and leap year check
// write the state and the result register.
// The input stays ready while the result register is empty or being taken.
// Reset returns the state to menu 0, all times 0 and the date 1 January 2019.
// ---------------------------------------------------------------------------
`default_nettype none

`include "clock_date_setting_editor_unit_assert.svh"

module clock_date_setting_editor_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output      logic                               s_axis_tready,
	// [2:0] mode, [7:3] load_day, [11:8] load_month, [25:12] load_year
	input  wire logic [cdse_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// [2:0] operation
	input  wire logic [cdse_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
	output      logic                               m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [2:0] setting_index, [7:3] time_hour, [13:8] time_minute,
	// [19:14] time_second, [24:20] alarm_hour, [30:25] alarm_minute,
	// [36:31] alarm_second, [41:37] date_day, [45:42] date_month,
	// [59:46] date_year, [60] alarm_off
	output      logic [cdse_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	// Input register.
	logic        s1_valid_q;
	logic [2:0]  op_s1;
	logic [2:0]  mode_s1;
	logic [4:0]  lday_s1;
	logic [3:0]  lmonth_s1;
	logic [13:0] lyear_s1;

	// Editor state and result register.
	cdse_pkg::cdse_state_t st_q;
	cdse_pkg::cdse_state_t st_d;
	logic                  off_d;
	logic                  m_valid_q;
	logic [cdse_pkg::OUT_TDATA_W-1:0] m_data_q;

	logic        advance;
	logic        up;
	logic [3:0]  month_up;
	logic [3:0]  month_dn;
	logic [13:0] year_up;
	logic [13:0] year_dn;
	logic [3:0]  dm;
	logic [13:0] dy;
	logic [4:0]  len;

	// The item in the input register moves on when the result register is free.
	assign advance       = s1_valid_q && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1     <= s_axis_tuser[2:0];
			mode_s1   <= s_axis_tdata[2:0];
			lday_s1   <= s_axis_tdata[7:3];
			lmonth_s1 <= s_axis_tdata[11:8];
			lyear_s1  <= s_axis_tdata[25:12];
		end
	end

	// Candidate month and year; the day is measured against the month and year
	// that the step leaves behind.
	always_comb begin
		up       = (op_s1 == cdse_pkg::OP_UP);
		month_up = (st_q.cal_month >= 4'd12 || st_q.cal_month == 4'd0) ? 4'd1
			: st_q.cal_month + 4'd1;
		month_dn = (st_q.cal_month <= 4'd1) ? 4'd12 : st_q.cal_month - 4'd1;
		year_up  = (st_q.cal_year >= cdse_pkg::YEAR_MAX) ? cdse_pkg::YEAR_MAX
			: st_q.cal_year + 14'd1;
		year_dn  = (st_q.cal_year != 14'd0) ? st_q.cal_year - 14'd1 : st_q.cal_year;
		dm = st_q.cal_month;
		dy = st_q.cal_year;
		if (st_q.dcur == cdse_pkg::CUR_SECOND) begin
			dm = up ? month_up : month_dn;
		end else if (st_q.dcur == cdse_pkg::CUR_THIRD) begin
			dy = up ? year_up : year_dn;
		end
		len = cdse_pkg::month_len(dm, dy);
	end

	// Next state for the item in the input register.
	always_comb begin
		st_d  = st_q;
		off_d = 1'b0;
		unique case (op_s1)
			cdse_pkg::OP_LEFT, cdse_pkg::OP_RIGHT: begin
				if (mode_s1 == cdse_pkg::MODE_STANDARD) begin
					st_d.menu = (op_s1 == cdse_pkg::OP_LEFT) ? cdse_pkg::menu_left(st_q.menu)
						: cdse_pkg::menu_right(st_q.menu);
				end else if (mode_s1 == cdse_pkg::MODE_TIME) begin
					st_d.tcur = (op_s1 == cdse_pkg::OP_LEFT) ? cdse_pkg::cursor_left(st_q.tcur)
						: cdse_pkg::cursor_right(st_q.tcur);
				end else if (mode_s1 == cdse_pkg::MODE_ALARM) begin
					st_d.acur = (op_s1 == cdse_pkg::OP_LEFT) ? cdse_pkg::cursor_left(st_q.acur)
						: cdse_pkg::cursor_right(st_q.acur);
				end else if (mode_s1 == cdse_pkg::MODE_DATE) begin
					st_d.dcur = (op_s1 == cdse_pkg::OP_LEFT) ? cdse_pkg::cursor_left(st_q.dcur)
						: cdse_pkg::cursor_right(st_q.dcur);
				end
			end
			cdse_pkg::OP_UP, cdse_pkg::OP_DOWN: begin
				if (mode_s1 == cdse_pkg::MODE_TIME) begin
					if (st_q.tcur == cdse_pkg::CUR_FIRST) begin
						st_d.set_hour = 5'(cdse_pkg::hms_step({1'b0, st_q.set_hour},
							cdse_pkg::HOUR_TOP, up));
					end else if (st_q.tcur == cdse_pkg::CUR_SECOND) begin
						st_d.set_minute = cdse_pkg::hms_step(st_q.set_minute,
							cdse_pkg::MINSEC_TOP, up);
					end else if (st_q.tcur == cdse_pkg::CUR_THIRD) begin
						st_d.set_second = cdse_pkg::hms_step(st_q.set_second,
							cdse_pkg::MINSEC_TOP, up);
					end
				end else if (mode_s1 == cdse_pkg::MODE_ALARM) begin
					if (st_q.acur == cdse_pkg::CUR_FIRST) begin
						st_d.wake_hour = 5'(cdse_pkg::hms_step({1'b0, st_q.wake_hour},
							cdse_pkg::HOUR_TOP, up));
					end else if (st_q.acur == cdse_pkg::CUR_SECOND) begin
						st_d.wake_minute = cdse_pkg::hms_step(st_q.wake_minute,
							cdse_pkg::MINSEC_TOP, up);
					end else if (st_q.acur == cdse_pkg::CUR_THIRD) begin
						st_d.wake_second = cdse_pkg::hms_step(st_q.wake_second,
							cdse_pkg::MINSEC_TOP, up);
					end
				end else if (mode_s1 == cdse_pkg::MODE_DATE) begin
					if (st_q.dcur == cdse_pkg::CUR_FIRST) begin
						// Day step; an invalid month leaves the day alone.
						if (len != 5'd0) begin
							if (up) begin
								st_d.cal_day = (st_q.cal_day >= len) ? 5'd1 : st_q.cal_day + 5'd1;
							end else begin
								st_d.cal_day = (st_q.cal_day <= 5'd1) ? len : st_q.cal_day - 5'd1;
							end
						end
					end else if (st_q.dcur != cdse_pkg::CUR_NONE) begin
						// Month or year step with the day clamped to the new length.
						st_d.cal_month = dm;
						st_d.cal_year  = dy;
						if (len != 5'd0 && st_q.cal_day > len) begin
							st_d.cal_day = len;
						end
					end
				end
			end
			cdse_pkg::OP_CENTER: begin
				off_d = (mode_s1 == cdse_pkg::MODE_RINGING);
			end
			cdse_pkg::OP_LOAD: begin
				st_d.cal_day   = lday_s1;
				st_d.cal_month = lmonth_s1;
				st_d.cal_year  = lyear_s1;
			end
			default: begin
				st_d = st_q;
			end
		endcase
	end

	// Editor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{menu: 3'd0, tcur: cdse_pkg::CUR_FIRST, acur: cdse_pkg::CUR_FIRST,
				dcur: cdse_pkg::CUR_FIRST, set_hour: 5'd0, set_minute: 6'd0,
				set_second: 6'd0, wake_hour: 5'd0, wake_minute: 6'd0, wake_second: 6'd0,
				cal_day: cdse_pkg::CAL_DAY_RST, cal_month: cdse_pkg::CAL_MONTH_RST,
				cal_year: cdse_pkg::CAL_YEAR_RST};
		end else if (advance) begin
			st_q <= st_d;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result register payload: the state after the update.
	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {3'd0, off_d, st_d.cal_year, st_d.cal_month, st_d.cal_day,
				st_d.wake_second, st_d.wake_minute, st_d.wake_hour,
				st_d.set_second, st_d.set_minute, st_d.set_hour, st_d.menu};
		end
	end

	// Cursors only ever take the three field positions.
	`CDSE_ASSERT_SAME(a_cursor_legal, 1'b1, st_q.tcur != cdse_pkg::CUR_NONE && st_q.acur != cdse_pkg::CUR_NONE && st_q.dcur != cdse_pkg::CUR_NONE)
	// An item leaving the input register always lands in the result register.
	`CDSE_ASSERT_NEXT(a_advance_fills, advance, m_valid_q)
	// The state only changes when an item is applied.
	`CDSE_ASSERT_NEXT(a_state_frozen, !advance, $stable(st_q))
	// A blocked item stays in the input register unchanged.
	`CDSE_ASSERT_NEXT(a_s1_hold, s1_valid_q && !advance, s1_valid_q && $stable(op_s1) && $stable(mode_s1))
	// The alarm-off pulse reaches the result beat.
	`CDSE_ASSERT_NEXT(a_off_pulse, advance && off_d, m_data_q[60])

endmodule

`default_nettype wire
